// File: rtl/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared widths, register codes and controller/datapath interface structs
// for the Bellman-Ford shortest path core.
// ----------------------------------------------------------------------------
package bfsp_pkg;

	localparam int NODE_W   = 6;   // node id width
	localparam int NCOUNT_W = 7;   // node_count register width
	localparam int WEIGHT_W = 16;  // edge weight width
	localparam int DIST_W   = 32;  // distance width
	localparam int EDGE_W   = 2 * NODE_W + WEIGHT_W;  // packed edge word

	// register codes, taken from paddr[2]
	localparam logic REG_NODE_COUNT  = 1'b0;
	localparam logic REG_SOURCE_NODE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load_we;    // store incoming edge word
		logic clr_load;   // drop stored graph and overflow flag
		logic init_dist;  // clear reached bits, seed source
		logic edge_rd;    // read edge at current edge index
		logic j_clr;
		logic j_inc;
		logic pass_clr;
		logic pass_inc;
		logic dist_rd;    // read distances of both edge ends
		logic relax;      // relax current edge
		logic node_clr;
		logic node_rd;    // read distance of current output node
		logic node_inc;
		logic emit;       // present result for current node
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic edges_empty;
		logic single_node;
		logic j_last;
		logic pass_last;
		logic node_last;
	} sts_t;

endpackage

// File: rtl/bfsp_ctrl.sv
// ----------------------------------------------------------------------------
// bfsp_ctrl
// Sequencer: edge load, distance init, relaxation passes, result readout.
// ----------------------------------------------------------------------------
module bfsp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            last_edge,
	input  bfsp_pkg::sts_t  sts,
	output bfsp_pkg::cmd_t  cmd,
	output logic            busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_E_RD,
		ST_D_RD,
		ST_RELAX,
		ST_O_RD,
		ST_O_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && last_edge) state_q <= ST_INIT;
				end
				ST_INIT: begin
					if (sts.single_node || sts.edges_empty) state_q <= ST_O_RD;
					else state_q <= ST_E_RD;
				end
				ST_E_RD:  state_q <= ST_D_RD;
				ST_D_RD:  state_q <= ST_RELAX;
				ST_RELAX: begin
					if (sts.j_last && sts.pass_last) state_q <= ST_O_RD;
					else state_q <= ST_E_RD;
				end
				ST_O_RD:  state_q <= ST_O_EMIT;
				ST_O_EMIT: begin
					if (sts.node_last) state_q <= ST_IDLE;
					else state_q <= ST_O_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load_we = accept;
			ST_INIT: begin
				cmd.init_dist = 1'b1;
				cmd.j_clr     = 1'b1;
				cmd.pass_clr  = 1'b1;
				cmd.node_clr  = 1'b1;
			end
			ST_E_RD: cmd.edge_rd = 1'b1;
			ST_D_RD: cmd.dist_rd = 1'b1;
			ST_RELAX: begin
				cmd.relax = 1'b1;
				if (sts.j_last) begin
					cmd.j_clr    = 1'b1;
					cmd.pass_inc = !sts.pass_last;
				end else begin
					cmd.j_inc = 1'b1;
				end
			end
			ST_O_RD: cmd.node_rd = 1'b1;
			ST_O_EMIT: begin
				cmd.emit     = 1'b1;
				cmd.node_inc = !sts.node_last;
				cmd.clr_load = sts.node_last;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: rtl/bfsp_datapath.sv
// ----------------------------------------------------------------------------
// bfsp_datapath
// Edge store, distance store with reached bits, saturating relax unit,
// loop counters and result registers.
// ----------------------------------------------------------------------------
module bfsp_datapath #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bfsp_pkg::cmd_t                        cmd,
	output bfsp_pkg::sts_t                        sts,
	input  logic [bfsp_pkg::NCOUNT_W-1:0]         node_count,
	input  logic [bfsp_pkg::NODE_W-1:0]           source_node,
	input  logic [bfsp_pkg::NODE_W-1:0]           edge_from,
	input  logic [bfsp_pkg::NODE_W-1:0]           edge_to,
	input  logic signed [bfsp_pkg::WEIGHT_W-1:0]  edge_weight,
	output logic                                  result_valid,
	output logic [bfsp_pkg::NODE_W-1:0]           node_index,
	output logic signed [bfsp_pkg::DIST_W-1:0]    path_length,
	output logic                                  reachable,
	output logic                                  last_node,
	output logic                                  edges_dropped
);

	localparam int NA_W = $clog2(MAX_NODES);
	localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EC_W = $clog2(MAX_EDGES + 1);
	localparam int NW   = bfsp_pkg::NODE_W;
	localparam int CW   = bfsp_pkg::NCOUNT_W;
	localparam int DW   = bfsp_pkg::DIST_W;
	localparam int WW   = bfsp_pkg::WEIGHT_W;

	// edge store
	logic [bfsp_pkg::EDGE_W-1:0] edge_mem [MAX_EDGES];
	logic [bfsp_pkg::EDGE_W-1:0] edge_q;
	logic [EC_W-1:0]             loaded_q;
	logic                        overflow_q;
	logic [EA_W-1:0]             j_q;
	logic [NW-1:0]               pass_q;
	logic [NA_W-1:0]             node_q;

	// distance store
	logic signed [DW-1:0] dist_mem [MAX_NODES];
	logic signed [DW-1:0] rd_a_q;
	logic signed [DW-1:0] rd_b_q;
	logic [MAX_NODES-1:0] ok_q;

	logic [CW-1:0]        n_eff;
	logic [NW-1:0]        ea, eb;
	logic signed [WW-1:0] ew;
	logic                 a_in, b_in, src_in;
	logic [NA_W-1:0]      a_idx, b_idx, src_idx;
	logic signed [DW:0]   sum;
	logic signed [DW-1:0] cand;
	logic                 upd;
	logic                 wr_en;
	logic [NA_W-1:0]      wr_addr;
	logic signed [DW-1:0] wr_data;

	// node count clamped to 1 .. MAX_NODES
	always_comb begin
		if (node_count == '0) n_eff = CW'(1);
		else if (node_count > CW'(MAX_NODES)) n_eff = CW'(MAX_NODES);
		else n_eff = node_count;
	end

	assign ea = edge_q[bfsp_pkg::EDGE_W-1 -: NW];
	assign eb = edge_q[WW+NW-1 -: NW];
	assign ew = edge_q[WW-1:0];

	assign a_in    = {1'b0, ea} < n_eff;
	assign b_in    = {1'b0, eb} < n_eff;
	assign src_in  = {1'b0, source_node} < n_eff;
	assign a_idx   = ea[NA_W-1:0];
	assign b_idx   = eb[NA_W-1:0];
	assign src_idx = source_node[NA_W-1:0];

	// saturating add, then compare against current distance of the end node
	always_comb begin
		sum = {rd_a_q[DW-1], rd_a_q} + {{(DW+1-WW){ew[WW-1]}}, ew};
		if (sum[DW] != sum[DW-1])
			cand = sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		else
			cand = sum[DW-1:0];
		upd = a_in && b_in && ok_q[a_idx] && (!ok_q[b_idx] || (cand < rd_b_q));
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = b_idx;
		wr_data = cand;
		if (cmd.init_dist) begin
			wr_en   = src_in;
			wr_addr = src_idx;
			wr_data = '0;
		end else if (cmd.relax) begin
			wr_en = upd;
		end
	end

	// edge memory
	always_ff @(posedge clk) begin
		if (cmd.load_we && (loaded_q < EC_W'(MAX_EDGES)))
			edge_mem[loaded_q[EA_W-1:0]] <= {edge_from, edge_to, edge_weight};
		if (cmd.edge_rd)
			edge_q <= edge_mem[j_q];
	end

	// distance memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en)
			dist_mem[wr_addr] <= wr_data;
		if (cmd.dist_rd) begin
			rd_a_q <= dist_mem[a_idx];
			rd_b_q <= dist_mem[b_idx];
		end else if (cmd.node_rd) begin
			rd_a_q <= dist_mem[node_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q   <= '0;
			overflow_q <= 1'b0;
			j_q        <= '0;
			pass_q     <= '0;
			node_q     <= '0;
			ok_q       <= '0;
		end else begin
			if (cmd.clr_load) begin
				loaded_q   <= '0;
				overflow_q <= 1'b0;
			end else if (cmd.load_we) begin
				if (loaded_q < EC_W'(MAX_EDGES)) loaded_q <= loaded_q + EC_W'(1);
				else overflow_q <= 1'b1;
			end

			if (cmd.j_clr) j_q <= '0;
			else if (cmd.j_inc) j_q <= j_q + EA_W'(1);

			if (cmd.pass_clr) pass_q <= '0;
			else if (cmd.pass_inc) pass_q <= pass_q + NW'(1);

			if (cmd.node_clr) node_q <= '0;
			else if (cmd.node_inc) node_q <= node_q + NA_W'(1);

			// init: only the source is reached, if it is in range
			if (cmd.init_dist) begin
				ok_q <= src_in ? (MAX_NODES'(1) << src_idx) : '0;
			end else if (cmd.relax && upd) begin
				ok_q[b_idx] <= 1'b1;
			end
		end
	end

	assign sts.edges_empty = (loaded_q == '0);
	assign sts.single_node = (n_eff == CW'(1));
	assign sts.j_last      = (EC_W'(j_q) + EC_W'(1)) == loaded_q;
	assign sts.pass_last   = (CW'(pass_q) + CW'(2)) == n_eff;
	assign sts.node_last   = (CW'(node_q) + CW'(1)) == n_eff;

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			node_index    <= NW'(node_q);
			path_length   <= ok_q[node_q] ? rd_a_q : '0;
			reachable     <= ok_q[node_q];
			last_node     <= sts.node_last;
			edges_dropped <= overflow_q;
		end
	end

endmodule

// File: rtl/bellman_ford_shortest_paths_core.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_core
// Single-source shortest paths over a directed weighted graph, Bellman-Ford.
// ----------------------------------------------------------------------------
// Usage:
//  - Edge words enter on start/busy: a word is taken on a rising edge with
//    start high and busy low. One edge word per cycle while loading.
//  - The word with last_edge set starts the compute; busy rises next cycle.
//  - Compute: an init step, then (node_count - 1) passes over all stored
//    edges, each edge in turn by edge read, distance read and relax/write.
//    Passes are skipped for a single node or an empty store.
//  - Readout: one result word per node 0 .. node_count - 1, each on
//    result_valid for exactly one cycle. The receiver cannot stall;
//    results must be taken as they appear. last_node marks the final
//    one. busy falls with the last result issued.
//  - Edges past MAX_EDGES are dropped; edges_dropped reports it for the graph.
//  - Config (node_count, source_node) via APB at 0x0 / 0x4, written idle.
//  - Reset: store empty, node_count = 64, source_node = 0, no result pending.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths_core #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB config
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	// edge words
	input  logic                                  start,
	output logic                                  busy,
	input  logic [bfsp_pkg::NODE_W-1:0]           edge_from,
	input  logic [bfsp_pkg::NODE_W-1:0]           edge_to,
	input  logic signed [bfsp_pkg::WEIGHT_W-1:0]  edge_weight,
	input  logic                                  last_edge,
	// result words
	output logic                                  result_valid,
	output logic [bfsp_pkg::NODE_W-1:0]           node_index,
	output logic signed [bfsp_pkg::DIST_W-1:0]    path_length,
	output logic                                  reachable,
	output logic                                  last_node,
	output logic                                  edges_dropped
);

	logic [bfsp_pkg::NCOUNT_W-1:0] node_count_q;
	logic [bfsp_pkg::NODE_W-1:0]   source_node_q;
	logic                          accept;
	bfsp_pkg::cmd_t                cmd;
	bfsp_pkg::sts_t                sts;

	assign pready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= bfsp_pkg::NCOUNT_W'(64);
			source_node_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == bfsp_pkg::REG_NODE_COUNT)
				node_count_q <= pwdata[bfsp_pkg::NCOUNT_W-1:0];
			else
				source_node_q <= pwdata[bfsp_pkg::NODE_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == bfsp_pkg::REG_SOURCE_NODE)
			prdata = {{(32-bfsp_pkg::NODE_W){1'b0}}, source_node_q};
		else
			prdata = {{(32-bfsp_pkg::NCOUNT_W){1'b0}}, node_count_q};
	end

	assign accept = start && !busy;

	bfsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.last_edge (last_edge),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	bfsp_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.node_count    (node_count_q),
		.source_node   (source_node_q),
		.edge_from     (edge_from),
		.edge_to       (edge_to),
		.edge_weight   (edge_weight),
		.result_valid  (result_valid),
		.node_index    (node_index),
		.path_length   (path_length),
		.reachable     (reachable),
		.last_node     (last_node),
		.edges_dropped (edges_dropped)
	);

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bellman_ford_shortest_paths_core: edge words go in
// over start/busy, a local shortest-path solver predicts the per-node result
// words, and every result_valid word is compared against the oldest one.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_NODES     = 64;
	localparam int MAX_EDGES     = 1024;
	localparam int RANDOM_EDGES  = 420;    // random-phase stimulus size
	localparam int IDLE_HOLDOFF  = 8;      // settle cycles before a register write
	localparam int TAIL_CYCLES   = 24;     // quiet time after the last result
	localparam int STALL_LIMIT   = 100000; // watchdog bound on a stretch with no progress
	localparam int REPORT_LIMIT  = 10;

	// one stored edge, as the solver keeps it
	typedef struct packed {
		logic [bfsp_pkg::NODE_W-1:0]          src;
		logic [bfsp_pkg::NODE_W-1:0]          dst;
		logic signed [bfsp_pkg::WEIGHT_W-1:0] weight;
	} edge_word_t;

	// one result word, as the core should present it
	typedef struct packed {
		logic [bfsp_pkg::NODE_W-1:0]        node;
		logic signed [bfsp_pkg::DIST_W-1:0] length;
		logic                               reached;
		logic                               tail;
		logic                               dropped;
	} node_result_t;

	// ------------------------------------------------------------------
	// DUT connections; every input is known from time zero
	// ------------------------------------------------------------------
	logic                                 clk         = 1'b0;
	logic                                 arst_n      = 1'b0;
	logic                                 psel        = 1'b0;
	logic                                 penable     = 1'b0;
	logic                                 pwrite      = 1'b0;
	logic [2:0]                           paddr       = '0;
	logic [31:0]                          pwdata      = '0;
	logic [31:0]                          prdata;
	logic                                 pready;
	logic                                 start       = 1'b0;
	logic                                 busy;
	logic [bfsp_pkg::NODE_W-1:0]          edge_from   = '0;
	logic [bfsp_pkg::NODE_W-1:0]          edge_to     = '0;
	logic signed [bfsp_pkg::WEIGHT_W-1:0] edge_weight = '0;
	logic                                 last_edge   = 1'b0;
	logic                                 result_valid;
	logic [bfsp_pkg::NODE_W-1:0]          node_index;
	logic signed [bfsp_pkg::DIST_W-1:0]   path_length;
	logic                                 reachable;
	logic                                 last_node;
	logic                                 edges_dropped;

	bellman_ford_shortest_paths_core #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.busy          (busy),
		.edge_from     (edge_from),
		.edge_to       (edge_to),
		.edge_weight   (edge_weight),
		.last_edge     (last_edge),
		.result_valid  (result_valid),
		.node_index    (node_index),
		.path_length   (path_length),
		.reachable     (reachable),
		.last_node     (last_node),
		.edges_dropped (edges_dropped)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Solver state: a private copy of the registers and the edge store
	// ------------------------------------------------------------------
	logic [bfsp_pkg::NCOUNT_W-1:0] cfg_node_count = 7'd64;
	logic [bfsp_pkg::NODE_W-1:0]   cfg_source     = '0;
	edge_word_t                    graph_edges [MAX_EDGES];
	int unsigned                   edges_held     = 0;
	bit                            edges_lost     = 1'b0;

	node_result_t                  pending_nodes [$];  // predicted result words, oldest first
	int unsigned                   mismatch_count = 0;
	int unsigned                   words_sent     = 0;
	int unsigned                   burst_left     = 0;
	int unsigned                   stall_cycles   = 0;

	// node_count as the core uses it: 0 acts as 1, anything past 64 as 64
	function automatic int unsigned active_nodes();
		int unsigned n;
		n = cfg_node_count;
		if (n < 1)
			n = 1;
		if (n > MAX_NODES)
			n = MAX_NODES;
		return n;
	endfunction

	// Runs the fixed n-1 relaxation passes over the held edges and queues one
	// result word per node, then empties the store for the next graph.
	function automatic void solve_shortest_paths();
		int unsigned                        n;
		int unsigned                        pass;
		int unsigned                        j;
		bit                                 reached [MAX_NODES];
		logic signed [bfsp_pkg::DIST_W-1:0] path_dist [MAX_NODES];
		logic [bfsp_pkg::NODE_W-1:0]        a;
		logic [bfsp_pkg::NODE_W-1:0]        b;
		longint                             sum;
		logic signed [bfsp_pkg::DIST_W-1:0] cand;
		node_result_t                       res;
		n = active_nodes();
		for (int i = 0; i < MAX_NODES; i++) begin
			reached[i]   = 1'b0;
			path_dist[i] = '0;
		end
		// a source outside the active range reaches nothing
		if (cfg_source < n)
			reached[cfg_source] = 1'b1;
		for (pass = 0; pass + 1 < n; pass++) begin
			for (j = 0; j < edges_held; j++) begin
				a = graph_edges[j].src;
				b = graph_edges[j].dst;
				// skip edges touching unused nodes and edges from unreached nodes
				if (a >= n || b >= n || !reached[a])
					continue;
				sum = longint'(path_dist[a]) + longint'(graph_edges[j].weight);
				if (sum > longint'(32'sh7fff_ffff))
					cand = 32'sh7fff_ffff;
				else if (sum < -longint'(64'sh8000_0000))
					cand = 32'sh8000_0000;
				else
					cand = sum[bfsp_pkg::DIST_W-1:0];
				if (!reached[b] || cand < path_dist[b]) begin
					reached[b]   = 1'b1;
					path_dist[b] = cand;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			res.node    = bfsp_pkg::NODE_W'(i);
			res.length  = reached[i] ? path_dist[i] : '0;
			res.reached = reached[i];
			res.tail    = (i + 1 == n);
			res.dropped = edges_lost;
			pending_nodes.insert(pending_nodes.size(), res);
		end
		edges_held = 0;
		edges_lost = 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Drops start for a while; the fields carry junk meanwhile.
	task automatic pause_sender(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) begin
			edge_from   <= bfsp_pkg::NODE_W'($urandom);
			edge_to     <= bfsp_pkg::NODE_W'($urandom);
			edge_weight <= bfsp_pkg::WEIGHT_W'($urandom);
			last_edge   <= 1'($urandom);
			@(posedge clk);
		end
	endtask

	// Presents one edge word and holds it until the core takes it. start is
	// left high, unless a random pause follows, so the next word can follow in the very next cycle.
	task automatic send_edge(
		input logic [bfsp_pkg::NODE_W-1:0]          from_node,
		input logic [bfsp_pkg::NODE_W-1:0]          to_node,
		input logic signed [bfsp_pkg::WEIGHT_W-1:0] weight,
		input logic                                 is_last
	);
		start       <= 1'b1;
		edge_from   <= from_node;
		edge_to     <= to_node;
		edge_weight <= weight;
		last_edge   <= is_last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// taken at this edge
		words_sent++;
		if (edges_held < MAX_EDGES) begin
			graph_edges[edges_held] = '{src: from_node, dst: to_node, weight: weight};
			edges_held++;
		end else begin
			edges_lost = 1'b1;
		end
		if (is_last)
			solve_shortest_paths();
		// bursty sender: random-length runs, random gaps between them
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			pause_sender($urandom_range(1, 12));
			burst_left = $urandom_range(0, 24);
		end
	endtask

	// Waits until every predicted word has come out and the core is quiet.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_nodes.size() != 0)
			@(posedge clk);
		repeat (IDLE_HOLDOFF)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle. Only called with the core idle.
	task automatic write_reg(input logic code, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {code, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (code == bfsp_pkg::REG_NODE_COUNT)
			cfg_node_count = value[bfsp_pkg::NCOUNT_W-1:0];
		else
			cfg_source = value[bfsp_pkg::NODE_W-1:0];
	endtask

	// ------------------------------------------------------------------
	// Result checker: results cannot be held off, so every strobe counts
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		node_result_t exp_word;
		if (arst_n && result_valid) begin
			if (pending_nodes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result word: node %0d len %0d reach %0b",
						node_index, path_length, reachable);
			end else begin
				exp_word = pending_nodes.pop_front();
				if (node_index !== exp_word.node || path_length !== exp_word.length ||
					reachable !== exp_word.reached || last_node !== exp_word.tail ||
					edges_dropped !== exp_word.dropped) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"result mismatch: got node %0d len %0d reach %0b last %0b",
							" drop %0b, expected node %0d len %0d reach %0b last %0b drop %0b"},
							node_index, path_length, reachable, last_node, edges_dropped,
							exp_word.node, exp_word.length, exp_word.reached,
							exp_word.tail, exp_word.dropped);
				end
			end
		end
	end

	// Watchdog: any stretch with no word accepted either way is bounded.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-built graphs: weight extremes, edges on unused nodes, an edge out of
	// an unreached node, and a negative cycle sent right behind the first graph.
	task automatic test_directed_paths();
		drain_results();
		write_reg(bfsp_pkg::REG_NODE_COUNT, 32'd4);
		write_reg(bfsp_pkg::REG_SOURCE_NODE, 32'd0);
		send_edge(6'd0,  6'd1,  16'sh7fff, 1'b0);
		send_edge(6'd1,  6'd2,  16'sh8000, 1'b0);
		send_edge(6'd63, 6'd2,  -16'sd5,   1'b0);  // start node unused
		send_edge(6'd2,  6'd63, 16'sd1,    1'b0);  // end node unused
		send_edge(6'd3,  6'd0,  -16'sd100, 1'b0);  // node 3 not yet reached
		send_edge(6'd2,  6'd3,  16'sd0,    1'b1);
		// negative two-node cycle; node 3 stays unreached
		send_edge(6'd0,  6'd1,  -16'sd5,   1'b0);
		send_edge(6'd1,  6'd0,  -16'sd5,   1'b0);
		send_edge(6'd1,  6'd2,  -16'sd1,   1'b1);
	endtask

	// node_count outside 1..64 and a source outside the active nodes.
	task automatic test_range_clamps();
		drain_results();
		write_reg(bfsp_pkg::REG_NODE_COUNT, 32'd0);   // acts as one node, no passes
		write_reg(bfsp_pkg::REG_SOURCE_NODE, 32'd0);
		send_edge(6'd0, 6'd0, 16'sh8000, 1'b1);
		drain_results();
		write_reg(bfsp_pkg::REG_SOURCE_NODE, 32'd5);  // source past the single node
		send_edge(6'd5, 6'd0, 16'sd1, 1'b1);
		drain_results();
		write_reg(bfsp_pkg::REG_NODE_COUNT, 32'd127); // clamps to 64
		write_reg(bfsp_pkg::REG_SOURCE_NODE, 32'd63);
		send_edge(6'd63, 6'd0,  16'sh8000, 1'b0);
		send_edge(6'd0,  6'd62, 16'sh7fff, 1'b0);
		send_edge(6'd62, 6'd1,  -16'sd1,   1'b1);
		drain_results();
		write_reg(bfsp_pkg::REG_NODE_COUNT, 32'd8);
		write_reg(bfsp_pkg::REG_SOURCE_NODE, 32'd20); // nothing reachable
		send_edge(6'd20, 6'd1, 16'sd3, 1'b0);
		send_edge(6'd0,  6'd1, 16'sd1, 1'b1);
	endtask

	// More edges than the store holds, two nodes to keep the pass short. The
	// final word lands past capacity and must still start the compute; the
	// graph after it must report no drop.
	task automatic test_edge_overflow();
		drain_results();
		write_reg(bfsp_pkg::REG_NODE_COUNT, 32'd2);
		write_reg(bfsp_pkg::REG_SOURCE_NODE, 32'($urandom_range(0, 1)));
		for (int i = 0; i < MAX_EDGES + 6; i++)
			send_edge(bfsp_pkg::NODE_W'($urandom_range(0, 3)),
				bfsp_pkg::NODE_W'($urandom_range(0, 3)),
				bfsp_pkg::WEIGHT_W'($urandom), i == MAX_EDGES + 5);
		send_edge(6'd0, 6'd1, 16'sd7, 1'b1);
	endtask

	// Random graphs under random settings; mostly in-range edges so the
	// relaxation actually propagates, with some stray endpoints mixed in.
	task automatic test_random_graphs();
		int unsigned first_word;
		int unsigned n;
		int unsigned edge_total;
		logic [bfsp_pkg::NODE_W-1:0]          a;
		logic [bfsp_pkg::NODE_W-1:0]          b;
		logic signed [bfsp_pkg::WEIGHT_W-1:0] w;
		first_word = words_sent;
		while (words_sent - first_word < RANDOM_EDGES) begin
			if ($urandom_range(0, 2) == 0) begin
				drain_results();
				case ($urandom_range(0, 9))
					0:       n = 0;
					1:       n = 64;
					2:       n = $urandom_range(65, 127);
					3:       n = 1;
					4:       n = 2;
					default: n = $urandom_range(2, 16);
				endcase
				write_reg(bfsp_pkg::REG_NODE_COUNT, 32'(n));
				if ($urandom_range(0, 4) != 0)
					write_reg(bfsp_pkg::REG_SOURCE_NODE,
						32'($urandom_range(0, active_nodes() - 1)));
				else
					write_reg(bfsp_pkg::REG_SOURCE_NODE, 32'($urandom_range(0, 63)));
			end else if ($urandom_range(0, 5) == 0) begin
				drain_results();  // let the core empty out without a new setting
			end
			n = active_nodes();
			edge_total = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 20)
				: $urandom_range(21, 60);
			for (int i = 0; i < edge_total; i++) begin
				if ($urandom_range(0, 99) < 85) begin
					a = bfsp_pkg::NODE_W'($urandom_range(0, n - 1));
					b = bfsp_pkg::NODE_W'($urandom_range(0, n - 1));
				end else begin
					a = bfsp_pkg::NODE_W'($urandom);
					b = bfsp_pkg::NODE_W'($urandom);
				end
				case ($urandom_range(0, 7))
					0, 1, 2: w = bfsp_pkg::WEIGHT_W'($urandom_range(0, 200) - 100);
					3:       w = bfsp_pkg::WEIGHT_W'($urandom);
					4:       w = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
					default: w = bfsp_pkg::WEIGHT_W'($urandom_range(0, 2000) - 500);
				endcase
				send_edge(a, b, w, i == edge_total - 1);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_paths();
		test_range_clamps();
		test_edge_overflow();
		test_random_graphs();

		// all words in; wait out the last compute and readout
		start <= 1'b0;
		while (pending_nodes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);

		if (mismatch_count == 0 && pending_nodes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
